// ===== src/mpk_pkg.sv =====
`default_nettype none
package mpk_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int LVL_W = 6;
    localparam int IDX_W = 5;
    localparam int CNT_W = 33;

    localparam logic [2:0] PH_HEAD    = 3'd0;
    localparam logic [2:0] PH_GATHER  = 3'd1;
    localparam logic [2:0] PH_EXTTYPE = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;

    localparam logic [4:0] K_NIL     = 5'd0;
    localparam logic [4:0] K_FALSE   = 5'd1;
    localparam logic [4:0] K_TRUE    = 5'd2;
    localparam logic [4:0] K_UINT    = 5'd3;
    localparam logic [4:0] K_SINT    = 5'd4;
    localparam logic [4:0] K_F32     = 5'd5;
    localparam logic [4:0] K_F64     = 5'd6;
    localparam logic [4:0] K_STR     = 5'd7;
    localparam logic [4:0] K_BIN     = 5'd8;
    localparam logic [4:0] K_EXT     = 5'd9;
    localparam logic [4:0] K_ARR     = 5'd10;
    localparam logic [4:0] K_MAP     = 5'd11;
    localparam logic [4:0] K_PAYLOAD = 5'd12;
    localparam logic [4:0] K_ARR_END = 5'd13;
    localparam logic [4:0] K_MAP_END = 5'd14;
    localparam logic [4:0] K_BAD     = 5'd15;
    localparam logic [4:0] K_DEEP    = 5'd16;

    localparam logic [0:0] REG_MAX_DEPTH    = 1'd0;
    localparam logic [0:0] REG_REPORT_DEPTH = 1'd1;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [63:0] value;
        logic [7:0]  ext_code;
        logic [5:0]  nest_level;
        logic        is_map_key;
        logic        object_done;
        logic        last;
    } token_t;

    // Controller to datapath.
    typedef struct packed {
        logic in_take;     // consume the input byte (head/gather/ext/payload)
        logic pop_step;    // one step of the close cascade
        logic out_load;    // load output register with the built token
    } mpk_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic tok_valid;   // the byte (or cascade step) yields a token
        logic need_close;  // element completes the last entry of its open container
        logic cascade_more;// after this close step, another close step follows
    } mpk_sts_t;

endpackage
`default_nettype wire

// ===== src/mpk_stream_if.sv =====
`default_nettype none
interface mpk_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mpk_datapath.sv =====
`default_nettype none
module mpk_datapath
    import mpk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index_lo,
    input  wire logic        cfg_index_hi_zero,
    input  wire logic [5:0]  cfg_data,
    input  wire logic [7:0]  byte_in,
    input  wire mpk_cmd_t    cmd,
    output mpk_sts_t         sts,
    output token_t           tok
);

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [3:0]  gleft_reg, gleft_next;
    logic [63:0] gval_reg, gval_next;
    logic [31:0] pleft_reg, pleft_next;
    logic [5:0]  open_reg, open_next;
    logic        err_reg, err_next;
    logic [5:0]  maxd_reg, rptd_reg;

    logic [CNT_W-1:0] rem_mem [STACK_DEPTH];
    logic             map_mem [STACK_DEPTH];

    // Top-of-stack view.
    logic [IDX_W-1:0] top_idx;
    logic [CNT_W-1:0] top_rem, top_dec;
    logic             top_map;
    logic             key_top;
    logic [IDX_W-1:0] below_idx;
    logic             key_below;

    assign top_idx   = IDX_W'(open_reg - 6'd1);
    assign top_rem   = rem_mem[top_idx];
    assign top_map   = map_mem[top_idx];
    assign top_dec   = top_rem - CNT_W'(1);
    assign key_top   = (open_reg != 6'd0) && top_map && !top_rem[0];
    assign below_idx = IDX_W'(open_reg - 6'd2);
    assign key_below = (open_reg > 6'd1) && map_mem[below_idx] && !rem_mem[below_idx][0];

    logic [5:0] limit;
    assign limit = (maxd_reg < 6'(STACK_DEPTH)) ? maxd_reg : 6'(STACK_DEPTH);

    // Decode of the current byte or cascade step.
    token_t      t;
    logic        tv, complete, push, push_map;
    logic [CNT_W-1:0] push_cnt;
    logic [63:0] gv_sh, gv_ext;
    logic [3:0]  gl_dec;
    logic [7:0]  b;
    assign b = byte_in;

    always_comb
    begin
        t          = '0;
        tv         = 1'b0;
        complete   = 1'b0;
        push       = 1'b0;
        push_map   = 1'b0;
        push_cnt   = '0;
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        gleft_next = gleft_reg;
        gval_next  = gval_reg;
        pleft_next = pleft_reg;
        err_next   = err_reg;
        gv_sh      = {gval_reg[55:0], b};
        gl_dec     = (gleft_reg != 4'd0) ? gleft_reg - 4'd1 : 4'd0;
        gv_ext     = gv_sh;
        t.is_map_key = key_top;
        if (cmd.pop_step)
        begin
            tv = 1'b1;
            t.token_kind = top_map ? K_MAP_END : K_ARR_END;
            t.is_map_key = key_below;
        end
        else if (!err_reg)
        begin
            unique case (phase_reg)
                PH_GATHER:
                begin
                    gval_next  = gv_sh;
                    gleft_next = gl_dec;
                    if (gl_dec == 4'd0)
                    begin
                        phase_next = PH_HEAD;
                        if (hdr_reg >= 8'hc4 && hdr_reg <= 8'hc6)
                        begin
                            tv = 1'b1; t.token_kind = K_BIN; t.value = gv_sh;
                            if (gv_sh == 64'd0) complete = 1'b1;
                            else begin pleft_next = gv_sh[31:0]; phase_next = PH_PAYLOAD; end
                        end
                        else if (hdr_reg >= 8'hc7 && hdr_reg <= 8'hc9)
                        begin
                            pleft_next = gv_sh[31:0]; phase_next = PH_EXTTYPE;
                        end
                        else if (hdr_reg == 8'hca)
                        begin
                            tv = 1'b1; t.token_kind = K_F32; t.value = gv_sh; complete = 1'b1;
                        end
                        else if (hdr_reg == 8'hcb)
                        begin
                            tv = 1'b1; t.token_kind = K_F64; t.value = gv_sh; complete = 1'b1;
                        end
                        else if (hdr_reg >= 8'hcc && hdr_reg <= 8'hcf)
                        begin
                            tv = 1'b1; t.token_kind = K_UINT; t.value = gv_sh; complete = 1'b1;
                        end
                        else if (hdr_reg >= 8'hd0 && hdr_reg <= 8'hd3)
                        begin
                            case (hdr_reg[1:0])
                                2'd0: gv_ext = {{56{gv_sh[7]}}, gv_sh[7:0]};
                                2'd1: gv_ext = {{48{gv_sh[15]}}, gv_sh[15:0]};
                                2'd2: gv_ext = {{32{gv_sh[31]}}, gv_sh[31:0]};
                                default: gv_ext = gv_sh;
                            endcase
                            tv = 1'b1; t.token_kind = K_SINT; t.value = gv_ext; complete = 1'b1;
                        end
                        else if (hdr_reg >= 8'hd9 && hdr_reg <= 8'hdb)
                        begin
                            tv = 1'b1; t.token_kind = K_STR; t.value = gv_sh;
                            if (gv_sh == 64'd0) complete = 1'b1;
                            else begin pleft_next = gv_sh[31:0]; phase_next = PH_PAYLOAD; end
                        end
                        else if (hdr_reg >= 8'hdc && hdr_reg <= 8'hdf)
                        begin
                            push_map = hdr_reg[1];
                            tv = 1'b1;
                            t.token_kind = push_map ? K_MAP : K_ARR;
                            t.value = gv_sh;
                            if (gv_sh == 64'd0) complete = 1'b1;
                            else if (open_reg >= limit)
                            begin
                                t.token_kind = K_DEEP; t.is_map_key = 1'b0; err_next = 1'b1;
                            end
                            else
                            begin
                                push = 1'b1;
                                push_cnt = push_map ? {gv_sh[31:0], 1'b0} : {1'b0, gv_sh[31:0]};
                            end
                        end
                    end
                end
                PH_EXTTYPE:
                begin
                    tv = 1'b1; t.token_kind = K_EXT; t.value = {32'd0, pleft_reg};
                    t.ext_code = b;
                    if (pleft_reg == 32'd0) complete = 1'b1;
                    else phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    tv = 1'b1; t.token_kind = K_PAYLOAD; t.value = {56'd0, b};
                    if (pleft_reg > 32'd1) pleft_next = pleft_reg - 32'd1;
                    else begin pleft_next = 32'd0; complete = 1'b1; phase_next = PH_HEAD; end
                end
                default:
                begin
                    hdr_next = b;
                    if (b <= 8'h7f)
                    begin
                        tv = 1'b1; t.token_kind = K_UINT; t.value = {56'd0, b}; complete = 1'b1;
                    end
                    else if (b >= 8'he0)
                    begin
                        tv = 1'b1; t.token_kind = K_SINT; t.value = {56'hffffffffffffff, b};
                        complete = 1'b1;
                    end
                    else if (b >= 8'ha0 && b <= 8'hbf)
                    begin
                        tv = 1'b1; t.token_kind = K_STR; t.value = {59'd0, b[4:0]};
                        if (b[4:0] == 5'd0) complete = 1'b1;
                        else begin pleft_next = {27'd0, b[4:0]}; phase_next = PH_PAYLOAD; end
                    end
                    else if (b <= 8'h9f)
                    begin
                        push_map = !b[4];
                        tv = 1'b1;
                        t.token_kind = push_map ? K_MAP : K_ARR;
                        t.value = {60'd0, b[3:0]};
                        if (b[3:0] == 4'd0) complete = 1'b1;
                        else if (open_reg >= limit)
                        begin
                            t.token_kind = K_DEEP; t.is_map_key = 1'b0; err_next = 1'b1;
                        end
                        else
                        begin
                            push = 1'b1;
                            push_cnt = push_map ? {28'd0, b[3:0], 1'b0} : {29'd0, b[3:0]};
                        end
                    end
                    else if (b == 8'hc0)
                    begin
                        tv = 1'b1; t.token_kind = K_NIL; complete = 1'b1;
                    end
                    else if (b == 8'hc1)
                    begin
                        tv = 1'b1; t.token_kind = K_BAD; t.value = {56'd0, b};
                        t.is_map_key = 1'b0; err_next = 1'b1;
                    end
                    else if (b == 8'hc2 || b == 8'hc3)
                    begin
                        tv = 1'b1; t.token_kind = b[0] ? K_TRUE : K_FALSE; complete = 1'b1;
                    end
                    else if (b >= 8'hd4 && b <= 8'hd8)
                    begin
                        pleft_next = 32'd1 << (b - 8'hd4); phase_next = PH_EXTTYPE;
                    end
                    else
                    begin
                        gval_next = 64'd0; phase_next = PH_GATHER;
                        if (b <= 8'hc6)      gleft_next = 4'd1 << (b - 8'hc4);
                        else if (b <= 8'hc9) gleft_next = 4'd1 << (b - 8'hc7);
                        else if (b == 8'hca) gleft_next = 4'd4;
                        else if (b == 8'hcb) gleft_next = 4'd8;
                        else if (b <= 8'hcf) gleft_next = 4'd1 << (b - 8'hcc);
                        else if (b <= 8'hd3) gleft_next = 4'd1 << (b - 8'hd0);
                        else if (b <= 8'hdb) gleft_next = 4'd1 << (b - 8'hd9);
                        else if (b == 8'hdc || b == 8'hde) gleft_next = 4'd2;
                        else gleft_next = 4'd4;
                    end
                end
            endcase
            if (complete) phase_next = PH_HEAD;
        end
    end

    // Close handling: decrement the top count, on zero a close step follows.
    logic       close_now, dec_zero, pop_done;
    logic [5:0] tok_nest;
    logic       tok_done, tok_last;
    assign dec_zero = (top_dec == '0);
    assign pop_done = ((open_reg - 6'd1) <= rptd_reg);
    always_comb
    begin
        open_next = open_reg;
        close_now = 1'b0;
        if (cmd.pop_step)
            open_next = open_reg - 6'd1;
        else if (cmd.in_take && push)
            open_next = open_reg + 6'd1;
        tok_nest = push ? open_reg + 6'd1 : (cmd.pop_step ? open_reg - 6'd1 : open_reg);
        tok_done = 1'b0;
        tok_last = 1'b1;
        if (cmd.pop_step)
        begin
            // A close that leaves report depth or fewer levels open ends the cascade.
            if (pop_done) tok_done = 1'b1;
            else close_now = (open_reg > 6'd1) && (rem_mem[below_idx] == CNT_W'(1));
            tok_last = !close_now;
        end
        else if (complete)
        begin
            if (open_reg == 6'd0) tok_done = 1'b1;
            else close_now = dec_zero;
            tok_last = !close_now;
        end
    end

    assign sts.tok_valid    = tv;
    assign sts.need_close   = close_now && !cmd.pop_step;
    assign sts.cascade_more = close_now;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            hdr_reg   <= '0;
            gleft_reg <= '0;
            gval_reg  <= '0;
            pleft_reg <= '0;
            open_reg  <= '0;
            err_reg   <= 1'b0;
            maxd_reg  <= 6'd32;
            rptd_reg  <= 6'd0;
        end
        else
        begin
            if (cfg_we && cfg_index_hi_zero)
            begin
                if (cfg_index_lo == REG_MAX_DEPTH) maxd_reg <= cfg_data;
                else rptd_reg <= cfg_data;
            end
            if (cmd.in_take)
            begin
                phase_reg <= phase_next;
                hdr_reg   <= hdr_next;
                gleft_reg <= gleft_next;
                gval_reg  <= gval_next;
                pleft_reg <= pleft_next;
                err_reg   <= err_next;
            end
            if (cmd.in_take || cmd.pop_step) open_reg <= open_next;
        end
    end

    // Level stack: push writes a new entry, completion decrements the top, a close step decrements the entry below.
    always_ff @(posedge clk)
    begin
        if (cmd.in_take && push)
        begin
            rem_mem[IDX_W'(open_reg)] <= push_cnt;
            map_mem[IDX_W'(open_reg)] <= push_map;
        end
        else if (cmd.in_take && complete && open_reg != 6'd0)
            rem_mem[top_idx] <= top_dec;
        else if (cmd.pop_step && open_reg > 6'd1 && !pop_done)
            rem_mem[below_idx] <= rem_mem[below_idx] - CNT_W'(1);
    end

    // Token with the level and completion flags merged in.
    always_comb
    begin
        tok             = t;
        tok.nest_level  = tok_nest;
        tok.object_done = tok_done;
        tok.last        = tok_last;
    end

endmodule
`default_nettype wire

// ===== src/mpk_ctrl.sv =====
`default_nettype none
module mpk_ctrl
    import mpk_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mpk_sts_t sts,
    input  wire logic     out_free,
    output mpk_cmd_t      cmd
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_CLOSE = 1'b1;

    logic state_reg, state_next;

    // Input is taken in the run state when the output register can accept a token.
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLOSE:
            begin
                if (out_free)
                begin
                    cmd.pop_step = 1'b1;
                    cmd.out_load = 1'b1;
                    if (!sts.cascade_more) state_next = ST_RUN;
                end
            end
            default:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    cmd.in_take  = 1'b1;
                    cmd.out_load = sts.tok_valid;
                    if (sts.need_close) state_next = ST_CLOSE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_RUN;
        else state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== src/messagepack_stream_tokenizer.sv =====
`default_nettype none
// Output: a token is registered and appears in the cycle after its byte transfer.
// Throughput: one byte per cycle while the output register is free; a byte that closes
// containers stalls the input while the close loop emits one end token per closed container.
// Reset: rst_n is asynchronous, active low; parsing state, depth and errors clear,
// stack entries stay undefined until pushed.
module messagepack_stream_tokenizer
    import mpk_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [5:0] cfg_data,
    mpk_stream_if.sink   in_ch,
    mpk_stream_if.source out_ch
);

    mpk_cmd_t cmd;
    mpk_sts_t sts;
    token_t   tok;
    token_t   out_reg;
    logic     out_valid_reg;
    logic     out_free;
    logic     in_ready;

    assign out_free = !out_valid_reg || out_ch.ready;

    mpk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .out_free (out_free),
        .cmd      (cmd)
    );

    mpk_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index_lo      (cfg_index[0:0]),
        .cfg_index_hi_zero (cfg_index[2:1] == 2'd0),
        .cfg_data          (cfg_data),
        .byte_in           (in_ch.data),
        .cmd               (cmd),
        .sts               (sts),
        .tok               (tok)
    );

    assign in_ch.ready = in_ready;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (out_free) out_valid_reg <= cmd.out_load;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cmd.out_load) out_reg <= tok;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule
`default_nettype wire
